// ----- sv/kuart_pkg.sv -----
// Package for the kernel user-access record table: constants, codes, packing widths.
// No dependencies.
`default_nettype none
package kuart_pkg;
    localparam int unsigned DEFAULT_TABLE_DEPTH = 16;
    localparam int unsigned MAX_OUT             = 16;
    localparam logic [31:0] USER_LIMIT          = 32'h8000_0000;
    localparam logic [31:0] PAGE_MASK           = 32'hFFFF_F000;
    localparam logic [31:0] EXEMPT_RESET        = 32'h02B4_0020;

    localparam logic [1:0] KIND_FAULT   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_HOLDER  = 2'd2;
    // unused kind: accepted and dropped without a result
    localparam logic [1:0] KIND_NONE    = 2'd3;

    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_EXEMPT = 1'b1;

    localparam int unsigned S_TDATA_W = 136;
    localparam int unsigned M_TDATA_W = 40;
endpackage
`default_nettype wire

// ----- sv/kernel_user_access_record_table_unit.sv -----
// Top level of the kernel user-access record table.
// Depends on kuart_pkg.
//
// channel | dir | tdata (low bit first)                                  | tuser | tlast
// s_      | in  | context_req, thread_block, fault_address, fault_pc,    | kind  | -
//         |     | from_user, protection, is_write, code_rpl, align_check,|       |
//         |     | pte_writable                                           |       |
// m_      | out | violation, double_fetch, recorded, hit, released,      | -     | last
//         |     | released_address                                       |       |
// cfg     | in  | target_context (0), exempt_context (1)                 | -     | -
//
// An item passes through an accept step, a scan that fetches each entry in turn (the
// fetch of one entry overlaps the compare of the one before), and a step that loads
// the final beat into the output register. s_tready stays low until that load, so no
// new item is accepted before the final beat of the last one. A release holds back
// one freed entry so that last lands on the true final beat; the scan stalls while
// an earlier freed beat waits on m_tready, and the final load waits the same way.
// Reset is synchronous; the valid bits clear at once, entry contents are not cleared.
`default_nettype none
module kernel_user_access_record_table_unit
    import kuart_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // context_req, thread_block, fault_address, fault_pc, from_user, protection,
    // is_write, code_rpl, align_check, pte_writable, zero pad
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    // kind
    input  wire logic [1:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // violation, double_fetch, recorded, hit, released, released_address, zero pad
    output logic [M_TDATA_W-1:0]        m_tdata,
    output logic                        m_tlast,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_index,
    input  wire logic [31:0]            cfg_data
);
    localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned OW = $clog2(MAX_OUT + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [31:0] target_reg, exempt_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [31:0] ent_ctx [TABLE_DEPTH];
    logic [31:0] ent_pc  [TABLE_DEPTH];
    logic [31:0] ent_adr [TABLE_DEPTH];
    logic [31:0] ent_thr [TABLE_DEPTH];
    logic [CW-1:0] used_reg;
    logic [CW-1:0] idx_reg;
    logic [OW-1:0] nout_reg;

    logic [1:0]  kind_reg;
    logic [31:0] ctx_reg, thr_reg, adr_reg, pc_reg;
    logic        wr_reg, pass_reg, dbl_reg, found_reg;
    logic [IW-1:0] free_reg;
    logic [31:0] keep_adr_reg;

    // fetched entry
    logic          rd_live_reg, rd_v_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [31:0]   rd_ctx_reg, rd_pc_reg, rd_adr_reg, rd_thr_reg;

    logic        out_viol_reg, out_dbl_reg, out_rec_reg, out_hit_reg, out_rel_reg;
    logic        out_last_reg;
    logic [31:0] out_adr_reg;

    // unpack input beat
    logic [31:0] i_ctx, i_thr, i_adr, i_pc;
    logic i_user, i_prot, i_wr, i_ac, i_ptew, i_pass;
    logic [1:0] i_rpl;
    assign i_ctx  = s_tdata[31:0];
    assign i_thr  = s_tdata[63:32];
    assign i_adr  = s_tdata[95:64];
    assign i_pc   = s_tdata[127:96];
    assign i_user = s_tdata[128];
    assign i_prot = s_tdata[129];
    assign i_wr   = s_tdata[130];
    assign i_rpl  = s_tdata[132:131];
    assign i_ac   = s_tdata[133];
    assign i_ptew = s_tdata[134];
    assign i_pass = (i_ctx == target_reg) && (i_adr < USER_LIMIT) && i_prot &&
                    !(i_wr && !i_ptew) && !i_user && (i_rpl != 2'd3) && !i_ac;

    logic is_fault, is_hold, is_rel, in_take;
    assign is_fault = (kind_reg == KIND_FAULT);
    assign is_hold  = (kind_reg == KIND_HOLDER);
    assign is_rel   = (kind_reg == KIND_RELEASE);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready && (s_tuser != KIND_NONE);

    // shared compare unit on the most recently fetched entry
    logic c_dbl, c_free, c_hold, c_rel;
    assign c_dbl  = rd_live_reg && rd_v_reg && (rd_adr_reg == adr_reg) &&
                    (rd_pc_reg != pc_reg) && !wr_reg;
    assign c_free = rd_live_reg && !rd_v_reg;
    assign c_hold = rd_live_reg && rd_v_reg && !found_reg &&
                    ((rd_adr_reg & PAGE_MASK) == (adr_reg & PAGE_MASK)) &&
                    (rd_thr_reg == thr_reg);
    assign c_rel  = rd_live_reg && rd_v_reg && (ctx_reg != exempt_reg) &&
                    (nout_reg < OW'(MAX_OUT)) &&
                    (((rd_ctx_reg == ctx_reg) && (rd_thr_reg == thr_reg)) ||
                     (rd_thr_reg == 32'd0));

    // scan sequencing
    logic out_free, scan_stall, advance, fetch, scan_end, rel_emit, done_emit;
    logic take_fault, take_hold, take_rel, clr_en, rec_en;
    logic [IW-1:0] fetch_idx;
    assign out_free   = !m_tvalid || m_tready;
    assign scan_stall = is_rel && c_rel && found_reg && !out_free;
    assign advance    = (state_reg == ST_SCAN) && !scan_stall;
    assign fetch      = advance && (idx_reg != DEPTH_C);
    assign scan_end   = advance && (idx_reg == DEPTH_C);
    assign rel_emit   = advance && is_rel && c_rel && found_reg;
    assign done_emit  = (state_reg == ST_DONE) && out_free;
    assign take_fault = advance && is_fault && c_free && !found_reg;
    assign take_hold  = advance && is_hold && c_hold;
    assign take_rel   = advance && is_rel && c_rel;
    assign clr_en     = take_hold || take_rel;
    assign rec_en     = done_emit && is_fault && pass_reg && !dbl_reg && !wr_reg &&
                        found_reg && (used_reg < DEPTH_C);
    assign fetch_idx  = idx_reg[IW-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_take) state_next = ST_SCAN;
            ST_SCAN: if (scan_end) state_next = ST_DONE;
            ST_DONE: if (done_emit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // fields of the next result beat
    logic        beat_viol, beat_dbl, beat_rec, beat_hit, beat_rel, beat_last;
    logic [31:0] beat_adr;
    always_comb begin
        beat_viol = 1'b0;
        beat_dbl  = 1'b0;
        beat_rec  = 1'b0;
        beat_hit  = 1'b0;
        beat_rel  = found_reg;
        beat_adr  = found_reg ? keep_adr_reg : 32'd0;
        beat_last = 1'b1;
        if (rel_emit) begin
            // a newer freed entry follows this one
            beat_last = 1'b0;
        end else if (is_fault) begin
            beat_viol = pass_reg;
            beat_dbl  = pass_reg && dbl_reg;
            beat_rec  = rec_en;
            beat_rel  = 1'b0;
            beat_adr  = 32'd0;
        end else if (is_hold) begin
            beat_hit = found_reg;
        end
    end

    assign m_tdata = {3'd0, out_adr_reg, out_rel_reg, out_hit_reg, out_rec_reg,
                      out_dbl_reg, out_viol_reg};
    assign m_tlast = out_last_reg;

    // control, table bookkeeping and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            target_reg  <= 32'd0;
            exempt_reg  <= EXEMPT_RESET;
            valid_reg   <= '0;
            used_reg    <= '0;
            idx_reg     <= '0;
            nout_reg    <= '0;
            rd_live_reg <= 1'b0;
            dbl_reg     <= 1'b0;
            found_reg   <= 1'b0;
            m_tvalid    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_index == REG_TARGET) target_reg <= cfg_data;
                else                         exempt_reg <= cfg_data;
            end
            // free on release or holder hit, fill on a recorded read
            if (clr_en) begin
                valid_reg[rd_idx_reg] <= 1'b0;
                used_reg <= used_reg - CW'(1);
            end else if (rec_en) begin
                valid_reg[free_reg] <= 1'b1;
                used_reg <= used_reg + CW'(1);
            end
            // restart the scan on a new item, else advance one entry
            if (in_take) begin
                idx_reg     <= '0;
                nout_reg    <= '0;
                rd_live_reg <= 1'b0;
                dbl_reg     <= 1'b0;
                found_reg   <= 1'b0;
            end else if (advance) begin
                if (fetch) idx_reg <= idx_reg + CW'(1);
                rd_live_reg <= fetch;
                if (take_rel) nout_reg <= nout_reg + OW'(1);
                if (is_fault && c_dbl) dbl_reg <= 1'b1;
                if (take_fault || take_hold || take_rel) found_reg <= 1'b1;
            end
            // load a beat or drop valid once taken
            if (rel_emit || done_emit) m_tvalid <= 1'b1;
            else if (m_tready)         m_tvalid <= 1'b0;
        end
    end

    // item capture, scan results and output fields
    always_ff @(posedge aclk) begin
        if (in_take) begin
            kind_reg <= s_tuser;
            ctx_reg  <= i_ctx;
            thr_reg  <= i_thr;
            adr_reg  <= i_adr;
            pc_reg   <= i_pc;
            wr_reg   <= i_wr;
            pass_reg <= i_pass;
        end
        if (take_fault) free_reg <= rd_idx_reg;
        if (take_hold || take_rel) keep_adr_reg <= rd_adr_reg;
        if (rel_emit || done_emit) begin
            out_viol_reg <= beat_viol;
            out_dbl_reg  <= beat_dbl;
            out_rec_reg  <= beat_rec;
            out_hit_reg  <= beat_hit;
            out_rel_reg  <= beat_rel;
            out_adr_reg  <= beat_adr;
            out_last_reg <= beat_last;
        end
    end

    // table storage: write on record, fetch one entry per scan cycle unless the scan stalls
    always_ff @(posedge aclk) begin
        if (rec_en) begin
            ent_ctx[free_reg] <= ctx_reg;
            ent_pc[free_reg]  <= pc_reg;
            ent_adr[free_reg] <= adr_reg;
            ent_thr[free_reg] <= thr_reg;
        end
        if (fetch) begin
            rd_idx_reg <= fetch_idx;
            rd_v_reg   <= valid_reg[fetch_idx];
            rd_ctx_reg <= ent_ctx[fetch_idx];
            rd_pc_reg  <= ent_pc[fetch_idx];
            rd_adr_reg <= ent_adr[fetch_idx];
            rd_thr_reg <= ent_thr[fetch_idx];
        end
    end
endmodule
`default_nettype wire

// ----- sv/kuart_checker.sv -----
// Port-level checker for the kernel user-access record table, bound to the top level.
// Depends on kuart_pkg.
`default_nettype none
module kuart_checker
    import kuart_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [1:0]           s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic                 m_tlast
);
    // hold a stalled beat
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");
    // accepted item of a known kind makes block busy
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser != KIND_NONE) |=> !s_tready)
        else $error("ready right after accept");
    // double fetch only on a violation
    a_dbl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[0])
        else $error("double fetch without violation");
    // non-final beats are releases
    a_rel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[4])
        else $error("non-last beat without release");
endmodule

bind kernel_user_access_record_table_unit kuart_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast)
);
`default_nettype wire

// ----- test/kernel_user_access_record_table_unit_tb.sv -----
// Testbench for the kernel user-access record table: directed and random
// fault, release and holder-check beats checked against a built-in table model.
// Depends on kuart_pkg and kernel_user_access_record_table_unit.
`timescale 1ns / 1ps
`default_nettype none
module kernel_user_access_record_table_unit_tb;
    import kuart_pkg::*;

    localparam int DEPTH       = DEFAULT_TABLE_DEPTH;
    localparam int SETTLE      = DEPTH + 24;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] ctx;
        logic [31:0] teb;
        logic [31:0] addr;
        logic [31:0] pc;
        logic        user;
        logic        prot;
        logic        wr;
        logic [1:0]  rpl;
        logic        ac;
        logic        pte_w;
    } access_t;

    typedef struct packed {
        logic        viol;
        logic        dbl;
        logic        rec;
        logic        hit;
        logic        rel;
        logic [31:0] rel_addr;
        logic        last;
    } verdict_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [31:0]          cfg_data;

    // shadow of the table and its registers
    logic [31:0] watch_ctx;
    logic [31:0] skip_ctx;
    logic        slot_valid [DEPTH];
    logic [31:0] slot_ctx   [DEPTH];
    logic [31:0] slot_pc    [DEPTH];
    logic [31:0] slot_addr  [DEPTH];
    logic [31:0] slot_teb   [DEPTH];
    int          slots_used;

    verdict_t pending_verdicts[$];
    int       errors;
    int       cycles;
    logic     hold_req;
    logic [31:0] addr_pool [8];
    logic [31:0] teb_pool  [3];

    kernel_user_access_record_table_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Work out the verdicts one access causes and update the shadow table.
    task automatic predict_access(input access_t a);
        verdict_t v;
        logic     dbl;
        logic     rec;
        int       n;
        v = '0;
        v.last = 1'b1;
        dbl = 1'b0;
        rec = 1'b0;
        n = 0;
        case (a.kind)
            KIND_FAULT: begin
                if (a.ctx == watch_ctx && a.addr < USER_LIMIT && a.prot &&
                    !(a.wr && !a.pte_w) && !a.user && a.rpl != 2'd3 && !a.ac) begin
                    if (!a.wr) begin
                        for (int i = 0; i < DEPTH; i++)
                            if (!dbl && slot_valid[i] && slot_addr[i] == a.addr &&
                                slot_pc[i] != a.pc)
                                dbl = 1'b1;
                    end
                    if (!dbl && !a.wr && slots_used < DEPTH) begin
                        for (int i = 0; i < DEPTH; i++) begin
                            if (!rec && !slot_valid[i]) begin
                                slot_valid[i] = 1'b1;
                                slot_ctx[i]   = a.ctx;
                                slot_pc[i]    = a.pc;
                                slot_addr[i]  = a.addr;
                                slot_teb[i]   = a.teb;
                                slots_used++;
                                rec = 1'b1;
                            end
                        end
                    end
                    v.viol = 1'b1;
                    v.dbl  = dbl;
                    v.rec  = rec;
                end
                pending_verdicts.push_back(v);
            end
            KIND_RELEASE: begin
                if (a.ctx != skip_ctx) begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (n < MAX_OUT && slot_valid[i] &&
                            ((slot_ctx[i] == a.ctx && slot_teb[i] == a.teb) ||
                             slot_teb[i] == 32'd0)) begin
                            slot_valid[i] = 1'b0;
                            slots_used--;
                            v = '0;
                            v.rel = 1'b1;
                            v.rel_addr = slot_addr[i];
                            pending_verdicts.push_back(v);
                            n++;
                        end
                    end
                end
                if (n == 0) begin
                    v = '0;
                    v.last = 1'b1;
                    pending_verdicts.push_back(v);
                end else begin
                    pending_verdicts[$].last = 1'b1;
                end
            end
            KIND_HOLDER: begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (!v.hit && slot_valid[i] && slot_teb[i] == a.teb &&
                        (slot_addr[i] & PAGE_MASK) == (a.addr & PAGE_MASK)) begin
                        slot_valid[i] = 1'b0;
                        slots_used--;
                        v.hit = 1'b1;
                        v.rel = 1'b1;
                        v.rel_addr = slot_addr[i];
                    end
                end
                pending_verdicts.push_back(v);
            end
            default: ;
        endcase
    endtask

    // Offer one beat and hold it until the block takes it.
    task automatic send_access(input access_t a);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = a.kind;
        s_tdata  = '0;
        s_tdata[134:0] = {a.pte_w, a.ac, a.rpl, a.wr, a.prot, a.user,
                          a.pc, a.addr, a.teb, a.ctx};
        do @(posedge aclk); while (!s_tready);
        predict_access(a);
    endtask

    // Drop valid for a random gap now and then, so that bursts form.
    task automatic maybe_gap();
        if ($urandom_range(0, 3) == 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (idx == REG_TARGET) watch_ctx = value;
        else skip_ctx = value;
    endtask

    function automatic access_t clean_read(input logic [31:0] addr, input logic [31:0] pc,
                                           input logic [31:0] teb);
        access_t a;
        a = '0;
        a.kind = KIND_FAULT;
        a.ctx  = watch_ctx;
        a.teb  = teb;
        a.addr = addr;
        a.pc   = pc;
        a.prot = 1'b1;
        return a;
    endfunction

    function automatic access_t make_op(input logic [1:0] kind, input logic [31:0] ctx,
                                        input logic [31:0] teb, input logic [31:0] addr);
        access_t a;
        a = '0;
        a.kind = kind;
        a.ctx  = ctx;
        a.teb  = teb;
        a.addr = addr;
        return a;
    endfunction

    function automatic access_t random_access();
        access_t      a;
        int           pick;
        logic [191:0] noise;
        pick = $urandom_range(0, 99);
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        a = noise[$bits(access_t)-1:0];
        if (pick < 10) return a;          // raw noise, any kind
        if (pick < 62) begin
            a = clean_read(addr_pool[$urandom_range(0, 7)],
                           32'h0040_0000 | $urandom_range(0, 3),
                           teb_pool[$urandom_range(0, 2)]);
            a.wr    = ($urandom_range(0, 4) == 0);
            a.pte_w = 1'($urandom_range(0, 1));
            a.rpl   = 2'($urandom_range(0, 2));
            if ($urandom_range(0, 9) == 0) a.addr = $urandom;
            if ($urandom_range(0, 14) == 0) a.pc = $urandom;
            return a;
        end
        if (pick < 78) begin
            a.kind = KIND_RELEASE;
            case ($urandom_range(0, 3))
                0: a.ctx = skip_ctx;
                1: a.ctx = $urandom;
                default: a.ctx = watch_ctx;
            endcase
            a.teb = ($urandom_range(0, 9) == 0) ? $urandom : teb_pool[$urandom_range(0, 2)];
            return a;
        end
        if (pick < 96) begin
            a.kind = KIND_HOLDER;
            a.teb  = teb_pool[$urandom_range(0, 2)];
            a.addr = addr_pool[$urandom_range(0, 7)] ^ $urandom_range(0, 12'hFFF);
            return a;
        end
        a.kind = KIND_NONE;
        return a;
    endfunction

    // Each filter stage in turn, plus an unused kind.
    task automatic test_fault_filters();
        access_t a;
        write_reg(REG_TARGET, 32'h0000_1000);
        write_reg(REG_EXEMPT, 32'hFFFF_FFFF);
        a = clean_read(32'h0001_0000, 32'h1, 32'h7FFD_E000);
        a.ctx = 32'hFFFF_FFFF;  send_access(a);
        a = clean_read(USER_LIMIT, 32'h1, 32'h7FFD_E000);  send_access(a);
        a = clean_read(32'h7FFF_FFFF, 32'h1, 32'h7FFD_E000);
        a.prot = 1'b0;  send_access(a);
        a.prot = 1'b1;  a.wr = 1'b1;  send_access(a);
        a.wr = 1'b0;  a.user = 1'b1;  send_access(a);
        a.user = 1'b0;  a.rpl = 2'd3;  send_access(a);
        a.rpl = 2'd0;  a.ac = 1'b1;  send_access(a);
        a.ac = 1'b0;  a.wr = 1'b1;  a.pte_w = 1'b1;  send_access(a);
        a.kind = KIND_NONE;  send_access(a);
    endtask

    task automatic test_double_fetch();
        send_access(clean_read(32'h0001_0004, 32'h0000_0010, 32'h7FFD_E000));
        send_access(clean_read(32'h0001_0004, 32'hFFFF_FFFF, 32'h7FFD_E000));
        send_access(clean_read(32'h0001_0004, 32'h0000_0010, 32'h7FFD_E000));
        send_access(clean_read(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    endtask

    task automatic test_holder_and_release();
        send_access(make_op(KIND_HOLDER, 32'hDEAD_BEEF, 32'h7FFD_E000, 32'h0001_0FFF));
        send_access(make_op(KIND_HOLDER, 32'h0, 32'h7FFD_E000, 32'h0002_0004));
        send_access(make_op(KIND_RELEASE, skip_ctx, 32'h7FFD_E000, 32'h0));
        send_access(make_op(KIND_RELEASE, 32'h0000_2000, 32'h1234_0000, 32'h0));
        send_access(make_op(KIND_RELEASE, watch_ctx, 32'h7FFD_E000, 32'h0));
        send_access(make_op(KIND_RELEASE, watch_ctx, 32'h7FFD_E000, 32'h0));
    endtask

    // Fill every slot, overflow by one, then free them all at once.
    task automatic test_table_full();
        for (int i = 0; i <= DEPTH; i++) begin
            send_access(clean_read(32'h0030_0000 + 32'(i * 8), 32'h55, 32'h0));
            maybe_gap();
        end
        send_access(make_op(KIND_RELEASE, 32'h0BAD_0000, 32'h1, 32'h0));
        wait_drained();
    endtask

    task automatic test_random_phase(input logic [31:0] target, input logic [31:0] exempt,
                                     input int count);
        write_reg(REG_TARGET, target);
        write_reg(REG_EXEMPT, exempt);
        for (int i = 0; i < count; i++) begin
            send_access(random_access());
            maybe_gap();
        end
        wait_drained();
    endtask

    // Stall the result side for a long stretch while beats keep coming.
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++) send_access(random_access());
        wait_drained();
    endtask

    // Receiver stall pattern, with a long forced hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                hold_req = 1'b0;
                repeat (400) @(negedge aclk);
            end else if (cycles % 2000 < 600) begin
                m_tready = 1'b1;
            end else begin
                m_tready = ($urandom_range(0, 2) != 0);
            end
        end
    end

    // Compare every result beat with the oldest expectation.
    always @(posedge aclk) begin
        verdict_t want;
        verdict_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[0], m_tdata[1], m_tdata[2], m_tdata[3], m_tdata[4],
                   m_tdata[36:5], m_tlast};
            if (pending_verdicts.size() == 0) begin
                $display("%0t unexpected beat: expected none, actual %h", $realtime, got);
                errors++;
            end else begin
                want = pending_verdicts.pop_front();
                if (got !== want) begin
                    $display("%0t mismatch: expected %h, actual %h", $realtime, want, got);
                    errors++;
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[kernel_user_access_record_table_unit] ERROR");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        hold_req = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = REG_TARGET;
        cfg_data = '0;
        watch_ctx = 32'h0;
        skip_ctx = EXEMPT_RESET;
        slots_used = 0;
        for (int i = 0; i < DEPTH; i++) begin
            slot_valid[i] = 1'b0;
            slot_ctx[i] = '0;
            slot_pc[i] = '0;
            slot_addr[i] = '0;
            slot_teb[i] = '0;
        end
        for (int i = 0; i < 8; i++)
            addr_pool[i] = 32'h0040_1000 + 32'(i / 2) * 32'h1000 + 32'(i % 2) * 4;
        addr_pool[7] = 32'h7FFF_FFFC;
        teb_pool[0] = 32'h0;
        teb_pool[1] = 32'h7FFD_E000;
        teb_pool[2] = 32'h7FFD_F000;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_fault_filters();
        test_double_fetch();
        test_holder_and_release();
        wait_drained();
        test_table_full();
        test_random_phase(32'h0000_1000, EXEMPT_RESET, 30);
        test_random_phase(32'hFFFF_FFFF, 32'h0000_0000, 30);
        test_random_phase(32'h0000_0000, 32'hFFFF_FFFF, 30);
        test_backpressure();

        if (errors == 0 && pending_verdicts.size() == 0) begin
            $display("[kernel_user_access_record_table_unit] OK");
        end else begin
            $display("[kernel_user_access_record_table_unit] ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
sv/kuart_pkg.sv
sv/kernel_user_access_record_table_unit.sv
sv/kuart_checker.sv
test/kernel_user_access_record_table_unit_tb.sv
